// ===== rtl/core/rmst_pkg.sv =====
// Shared types and constants for the running mean / deviation / threshold block.
// Holds the field widths and the command and status types of the divide/root engine.
// Depends on nothing.
`default_nettype none

package rmst_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned COUNT_WIDTH_DEF  = 24;

  localparam int unsigned TOL_W      = 16;
  localparam int unsigned TOL_FRAC_W = 12;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned STDEV_W    = 23;

  localparam int unsigned OUT_FIELDS_W = 3 * OUT_W + SUM_W + STDEV_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Dividend and radicand width of the engine, and the width of a root.
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned STEP_W = 7;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } rmst_op_e;

  typedef struct packed {
    logic              start;
    rmst_op_e          op;
    logic [STEP_W-1:0] steps;
  } rmst_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rmst_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmst_divsqrt.sv =====
// Iterative divide and square-root engine built around one compare/subtract unit.
// Division retires one quotient bit per cycle, the root one result bit per cycle.
// Depends on rmst_pkg.
`default_nettype none

module rmst_divsqrt #(
  parameter int unsigned DIVISOR_W = rmst_pkg::COUNT_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  rmst_pkg::rmst_cmd_t      cmd_i,
  input  wire  [rmst_pkg::RAD_W-1:0]     operand_i,
  input  wire  [DIVISOR_W-1:0]           divisor_i,
  output rmst_pkg::rmst_sts_t            sts_o,
  output logic [rmst_pkg::RAD_W-1:0]     result_o
);
  import rmst_pkg::*;

  localparam int unsigned REM_W = (DIVISOR_W + 1 > ROOT_W + 2) ? DIVISOR_W + 1 : ROOT_W + 2;

  logic              busy_q;
  logic              done_q;
  rmst_op_e          op_q;
  logic [STEP_W-1:0] step_q;

  logic [REM_W-1:0]     rem_q;
  logic [RAD_W-1:0]     dq_q;
  logic [ROOT_W-1:0]    root_q;
  logic [DIVISOR_W-1:0] divisor_q;

  logic [REM_W-1:0] opa;
  logic [REM_W-1:0] opb;
  logic [REM_W-1:0] diff;
  logic             borrow;
  logic             ge;

  // The shared unit: a root step brings down two radicand bits and tries 4*root+1,
  // a divide step brings down one dividend bit and tries the divisor.
  always_comb begin
    if (op_q == OP_SQRT) begin
      opa = {rem_q[REM_W-3:0], dq_q[RAD_W-1 -: 2]};
      opb = REM_W'({root_q, 2'b01});
    end else begin
      opa = {rem_q[REM_W-2:0], dq_q[RAD_W-1]};
      opb = REM_W'(divisor_q);
    end
    {borrow, diff} = {1'b0, opa} - {1'b0, opb};
    ge = !borrow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        step_q <= cmd_i.steps;
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q     <= '0;
      dq_q      <= operand_i;
      root_q    <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : opa;
      if (op_q == OP_SQRT) begin
        dq_q   <= dq_q << 2;
        root_q <= {root_q[ROOT_W-2:0], ge};
      end else begin
        dq_q <= {dq_q[RAD_W-2:0], ge};
      end
    end
  end

  assign result_o   = (op_q == OP_SQRT) ? RAD_W'(root_q) : dq_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/running_mean_stdev_threshold.sv =====
// Running mean / standard deviation / threshold unit, top level.
// Input beat: tuser = mode (1 clears all statistics), tdata = signed Q24.0 sample.
// Every input beat yields one output beat with count, sum, mean, deviation,
// threshold (mean - tolerance * deviation, saturated) and a count-full flag.
// The tolerance register (unsigned Q4.12) is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, as the block does not enforce
// this. Reset sets it and all statistics to zero.
// Path from the accepted beat to the result beat:
//   clear, or a sample dropped because the count is full: threshold, multiply, output;
//   first sample: mean divide, accumulate, threshold, multiply, output;
//   later samples: a variance divide and a square root also run after the accumulate.
// The divides and the square root run on the shared engine, one result bit each.
// One item is in work at a time; s_axis_tready is high only between items.
// The result waits in an output register, so the next beat is taken while the
// receiver stalls; a finished item then waits until that register is free.
// Depends on rmst_pkg and rmst_divsqrt.
`default_nettype none

module running_mean_stdev_threshold #(
  parameter int unsigned SAMPLE_WIDTH = rmst_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = rmst_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [rmst_pkg::TOL_W-1:0]            cfg_wdata_i,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample
  input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // mode
  input  wire                                   s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // sample_count, sample_sum, running_mean, running_stdev, threshold, zero pad
  output logic [rmst_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // count_full
  output logic                                  m_axis_tuser
);
  import rmst_pkg::*;

  localparam int unsigned X_W   = SAMPLE_WIDTH + FRAC_W;
  localparam int unsigned DW    = X_W + 1;
  localparam int unsigned MW    = (SAMPLE_WIDTH + 1 > STDEV_W) ? SAMPLE_WIDTH + 1 : STDEV_W;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned AW    = ((PW > RAD_W) ? PW : RAD_W) + 1;
  localparam int unsigned SAT_W = 34;
  localparam int unsigned PAD_W = OUT_DATA_W - OUT_FIELDS_W;
  localparam int          OUT_MAX = 2 ** (OUT_W - 1) - 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV1 = 4'd1;
  localparam logic [3:0] S_MEAN = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_DIV2 = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_THR  = 4'd7;
  localparam logic [3:0] S_TMUL = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(OUT_MAX);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return hi[OUT_W-1:0];
    end else if (v < lo) begin
      return lo[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  // Control and statistics state.
  logic [3:0]             state_q, state_d;
  logic [TOL_W-1:0]       tol_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic signed [X_W-1:0]  mean_q, mean_d;
  logic [RAD_W-1:0]       m2_q, m2_d;
  logic [STDEV_W-1:0]     stdev_q, stdev_d;
  logic                   out_valid_q, out_valid_d;

  // Per-item working registers.
  logic signed [SAMPLE_WIDTH-1:0] smp_q, smp_d;
  logic [DW-1:0]          dmag_q, dmag_d;
  logic                   dneg_q, dneg_d;
  logic                   full_q, full_d;
  logic [MW-1:0]          ma_q, ma_d;
  logic [MW-1:0]          mb_q, mb_d;
  logic [PW-1:0]          prod_q;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic                   out_full_q, out_full_d;

  logic                           accept;
  logic signed [SAMPLE_WIDTH-1:0] smp_in;
  logic signed [X_W-1:0]          x_in;
  logic signed [DW-1:0]           delta_in;
  logic [DW-1:0]                  dmag_in;
  logic signed [X_W-1:0]          x_q;
  logic signed [DW-1:0]           delta2;
  logic [DW-1:0]                  dmag2;
  logic [DW-1:0]                  quot;
  logic [AW-1:0]                  acc;
  logic [RAD_W-1:0]               root;
  logic signed [SAMPLE_WIDTH-1:0] mean16;
  logic signed [OUT_W-1:0]        mean_sat;
  logic signed [SAT_W-1:0]        thr_ext;
  logic signed [OUT_W-1:0]        thr;

  rmst_cmd_t              eng_cmd;
  rmst_sts_t              eng_sts;
  logic [RAD_W-1:0]       eng_operand;
  logic [COUNT_WIDTH-1:0] eng_divisor;
  logic [RAD_W-1:0]       eng_result;

  rmst_divsqrt #(
    .DIVISOR_W(COUNT_WIDTH)
  ) u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (eng_cmd),
    .operand_i(eng_operand),
    .divisor_i(eng_divisor),
    .sts_o    (eng_sts),
    .result_o (eng_result)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign smp_in   = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign x_in     = {smp_in, {FRAC_W{1'b0}}};
  assign delta_in = DW'(x_in) - DW'(mean_q);
  assign dmag_in  = delta_in[DW-1] ? DW'(-delta_in) : DW'(delta_in);

  // Second delta is taken against the mean already updated by this sample.
  assign x_q    = {smp_q, {FRAC_W{1'b0}}};
  assign delta2 = DW'(x_q) - DW'(mean_q);
  assign dmag2  = delta2[DW-1] ? DW'(-delta2) : DW'(delta2);

  assign quot = eng_result[DW-1:0];
  assign acc  = AW'(m2_q) + AW'(prod_q);
  assign root = eng_result;

  // Mean rounded toward minus infinity is an arithmetic shift.
  assign mean16   = mean_q[X_W-1:FRAC_W];
  assign mean_sat = sat_out(SAT_W'(mean16));
  assign thr_ext  = SAT_W'(mean_sat) - SAT_W'(prod_q >> TOL_FRAC_W);
  assign thr      = sat_out(thr_ext);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    m2_d        = m2_q;
    stdev_d     = stdev_q;
    out_valid_d = out_valid_q;
    smp_d       = smp_q;
    dmag_d      = dmag_q;
    dneg_d      = dneg_q;
    full_d      = full_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    out_data_d  = out_data_q;
    out_full_d  = out_full_q;
    eng_cmd     = '0;
    eng_operand = '0;
    eng_divisor = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          full_d = 1'b0;
          if (s_axis_tuser) begin
            cnt_d   = '0;
            sum_d   = '0;
            mean_d  = '0;
            m2_d    = '0;
            stdev_d = '0;
            state_d = S_THR;
          end else if (&cnt_q) begin
            full_d  = 1'b1;
            state_d = S_THR;
          end else begin
            cnt_d         = cnt_q + 1'b1;
            sum_d         = sum_q + SUM_W'(smp_in);
            smp_d         = smp_in;
            dmag_d        = dmag_in;
            dneg_d        = delta_in[DW-1];
            eng_cmd.start = 1'b1;
            eng_cmd.op    = OP_DIV;
            eng_cmd.steps = STEP_W'(DW);
            eng_operand   = RAD_W'(dmag_in) << (RAD_W - DW);
            eng_divisor   = cnt_q + 1'b1;
            state_d       = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (eng_sts.done) begin
          mean_d  = dneg_q ? mean_q - X_W'(quot) : mean_q + X_W'(quot);
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        ma_d    = MW'(dmag_q >> FRAC_W);
        mb_d    = MW'(dmag2 >> FRAC_W);
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        m2_d = (|(acc >> RAD_W)) ? '1 : acc[RAD_W-1:0];
        if (cnt_q > COUNT_WIDTH'(1)) begin
          eng_cmd.start = 1'b1;
          eng_cmd.op    = OP_DIV;
          eng_cmd.steps = STEP_W'(RAD_W);
          eng_operand   = m2_d;
          eng_divisor   = cnt_q - 1'b1;
          state_d       = S_DIV2;
        end else begin
          state_d = S_THR;
        end
      end
      S_DIV2: begin
        if (eng_sts.done) begin
          eng_cmd.start = 1'b1;
          eng_cmd.op    = OP_SQRT;
          eng_cmd.steps = STEP_W'(ROOT_W);
          eng_operand   = eng_result;
          state_d       = S_SQRT;
        end
      end
      S_SQRT: begin
        if (eng_sts.done) begin
          stdev_d = (|(root >> STDEV_W)) ? '1 : root[STDEV_W-1:0];
          state_d = S_THR;
        end
      end
      S_THR: begin
        ma_d    = MW'(tol_q);
        mb_d    = MW'(stdev_q);
        state_d = S_TMUL;
      end
      S_TMUL: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {{PAD_W{1'b0}}, thr, stdev_q, mean_sat, sum_q, OUT_W'(cnt_q)};
          out_full_d  = full_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tol_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      stdev_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      mean_q      <= mean_d;
      m2_q        <= m2_d;
      stdev_q     <= stdev_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    dmag_q     <= dmag_d;
    dneg_q     <= dneg_d;
    full_q     <= full_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    prod_q     <= ma_q * mb_q;
    out_data_q <= out_data_d;
    out_full_q <= out_full_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_full_q;

`ifndef SYNTHESIS
  a_ready_engine_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !eng_sts.busy)
    else $error("input taken while the engine is still busy");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser |=> cnt_q == '0 && m2_q == '0 && stdev_q == '0)
    else $error("clear beat left statistics behind");

  a_count_moves_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> cnt_q == '0 || cnt_q == $past(cnt_q) + 1'b1)
    else $error("sample count jumped");

  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_sts.done |-> state_q == S_DIV1 || state_q == S_DIV2 || state_q == S_SQRT)
    else $error("engine finished while the sequencer was not waiting");
`endif

endmodule

`default_nettype wire
